// ===== hdl/bsd_pkg.sv =====
// Package: shared types, character constants and escape lookup for the backslash escape decoder
package bsd_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_ESCAPE  = 2'd1,
    MODE_OCTAL   = 2'd2,
    MODE_STOPPED = 2'd3
  } scan_mode_e;

  localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHR_ZERO      = 8'h30;
  localparam logic [7:0] CHR_SEVEN     = 8'h37;
  localparam logic [7:0] CHR_STOP      = 8'h63;
  localparam logic [1:0] OCTAL_DIGITS  = 2'd3;

  localparam int unsigned FIFO_DEPTH = 4;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic       stopped_by_c;
    logic       last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  typedef struct packed {
    logic       known;
    logic [7:0] code;
  } esc_t;

  function automatic esc_t escape_lookup(logic [7:0] c);
    esc_t e;
    e.known = 1'b1;
    unique case (c)
      8'h61:         e.code = 8'd7;
      8'h62:         e.code = 8'd8;
      8'h66:         e.code = 8'd12;
      8'h6E:         e.code = 8'd10;
      8'h72:         e.code = 8'd13;
      8'h74:         e.code = 8'd9;
      8'h76:         e.code = 8'd11;
      CHR_BACKSLASH: e.code = CHR_BACKSLASH;
      default: begin
        e.known = 1'b0;
        e.code  = 8'd0;
      end
    endcase
    return e;
  endfunction

endpackage

// ===== hdl/bsd_if.sv =====
// Interfaces: request channels into and out of the backslash escape decoder
interface bsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface bsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       string_done;
  logic       stopped_by_c;
  logic       last_of_run;

  modport source (output valid, output out_byte, output byte_valid, output string_done,
                  output stopped_by_c, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input string_done,
                  input stopped_by_c, input last_of_run, output ready);
endinterface

// ===== hdl/bsd_step.sv =====
// Input register, scan state and per-byte decode producing up to two results
module bsd_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [7:0]     in_byte_i,
  input  logic           in_eos_i,
  output logic           in_ready_o,
  input  logic           room_i,
  output bsd_pkg::push_t push_o
);

  logic                s1_valid_q;
  logic [7:0]          s1_byte_q;
  logic                s1_eos_q;
  bsd_pkg::scan_mode_e mode_q, mode_d;
  logic [7:0]          val_q, val_d;
  logic [1:0]          dig_q, dig_d;
  logic                adv;
  logic                take;
  logic [1:0]          n;
  bsd_pkg::result_t    r0, r1;
  bsd_pkg::esc_t       esc;
  logic                is_oct;
  logic [7:0]          oct_next;

  assign adv        = s1_valid_q & room_i;
  assign in_ready_o = ~s1_valid_q | room_i;
  assign take       = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      mode_q     <= bsd_pkg::MODE_NORMAL;
      val_q      <= 8'd0;
      dig_q      <= 2'd0;
    end else begin
      if (take) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        mode_q <= mode_d;
        val_q  <= val_d;
        dig_q  <= dig_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_byte_q <= in_byte_i;
      s1_eos_q  <= in_eos_i;
    end
  end

  assign esc      = bsd_pkg::escape_lookup(s1_byte_q);
  assign is_oct   = (s1_byte_q >= bsd_pkg::CHR_ZERO) && (s1_byte_q <= bsd_pkg::CHR_SEVEN);
  assign oct_next = {val_q[4:0], s1_byte_q[2:0]};

  always_comb begin
    r0     = '0;
    r1     = '0;
    n      = 2'd0;
    mode_d = mode_q;
    val_d  = val_q;
    dig_d  = dig_q;
    if (s1_eos_q) begin
      n              = 2'd1;
      r0.string_done = 1'b1;
      unique case (mode_q)
        bsd_pkg::MODE_ESCAPE: begin
          r0.out_byte   = bsd_pkg::CHR_BACKSLASH;
          r0.byte_valid = 1'b1;
        end
        bsd_pkg::MODE_OCTAL: begin
          r0.out_byte   = val_q;
          r0.byte_valid = 1'b1;
        end
        bsd_pkg::MODE_STOPPED: r0.stopped_by_c = 1'b1;
        default: ;
      endcase
      mode_d = bsd_pkg::MODE_NORMAL;
      val_d  = 8'd0;
      dig_d  = 2'd0;
    end else begin
      unique case (mode_q)
        bsd_pkg::MODE_NORMAL: begin
          if (s1_byte_q == bsd_pkg::CHR_BACKSLASH) begin
            mode_d = bsd_pkg::MODE_ESCAPE;
          end else begin
            n             = 2'd1;
            r0.out_byte   = s1_byte_q;
            r0.byte_valid = 1'b1;
          end
        end
        bsd_pkg::MODE_ESCAPE: begin
          mode_d = bsd_pkg::MODE_NORMAL;
          priority if (esc.known) begin
            n             = 2'd1;
            r0.out_byte   = esc.code;
            r0.byte_valid = 1'b1;
          end else if (s1_byte_q == bsd_pkg::CHR_STOP) begin
            mode_d = bsd_pkg::MODE_STOPPED;
          end else if (s1_byte_q == bsd_pkg::CHR_ZERO) begin
            mode_d = bsd_pkg::MODE_OCTAL;
            val_d  = 8'd0;
            dig_d  = 2'd0;
          end else begin
            n             = 2'd2;
            r0.out_byte   = bsd_pkg::CHR_BACKSLASH;
            r0.byte_valid = 1'b1;
            r1.out_byte   = s1_byte_q;
            r1.byte_valid = 1'b1;
          end
        end
        bsd_pkg::MODE_OCTAL: begin
          if (is_oct && (dig_q < bsd_pkg::OCTAL_DIGITS)) begin
            if (dig_q + 2'd1 == bsd_pkg::OCTAL_DIGITS) begin
              n             = 2'd1;
              r0.out_byte   = oct_next;
              r0.byte_valid = 1'b1;
              mode_d        = bsd_pkg::MODE_NORMAL;
              val_d         = 8'd0;
              dig_d         = 2'd0;
            end else begin
              val_d = oct_next;
              dig_d = dig_q + 2'd1;
            end
          end else begin
            // early end of octal run: flush value, then treat byte as normal
            n             = 2'd1;
            r0.out_byte   = val_q;
            r0.byte_valid = 1'b1;
            mode_d        = bsd_pkg::MODE_NORMAL;
            val_d         = 8'd0;
            dig_d         = 2'd0;
            if (s1_byte_q == bsd_pkg::CHR_BACKSLASH) begin
              mode_d = bsd_pkg::MODE_ESCAPE;
            end else begin
              n             = 2'd2;
              r1.out_byte   = s1_byte_q;
              r1.byte_valid = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
    r0.last_of_run = (n == 2'd1);
    r1.last_of_run = (n == 2'd2);
  end

  assign push_o.count = adv ? n : 2'd0;
  assign push_o.r0    = r0;
  assign push_o.r1    = r1;

endmodule

// ===== hdl/bsd_fifo.sv =====
// Result queue: takes up to two results a cycle, hands out one while out_ready_i is high
module bsd_fifo #(
  parameter int unsigned Depth = bsd_pkg::FIFO_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bsd_pkg::push_t   push_i,
  output logic             room_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bsd_pkg::result_t out_res_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bsd_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]  head_q, head_d, tail_q, tail_d, tail_nx;
  logic [CntW-1:0]  count_q, count_d;
  logic             pop;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign pop         = out_valid_o & out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_res_o   = mem_q[head_q];
  assign room_o      = (count_q <= CntW'(Depth - 2));
  assign tail_nx     = ptr_inc(tail_q);

  always_comb begin
    head_d  = pop ? ptr_inc(head_q) : head_q;
    count_d = count_q + CntW'(push_i.count) - CntW'(pop);
    unique case (push_i.count)
      2'd1:    tail_d = tail_nx;
      2'd2:    tail_d = ptr_inc(tail_nx);
      default: tail_d = tail_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[tail_q] <= push_i.r0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[tail_nx] <= push_i.r1;
    end
  end

endmodule

// ===== hdl/backslash_escape_decoder.sv =====
// Top level: printf %b backslash escape expander, one string byte per request
//
//   channel | dir | payload                                              | handshake
//   in_i    | in  | in_byte, end_of_string                               | valid/ready
//   out_o   | out | out_byte, byte_valid, string_done, stopped_by_c,     | valid/ready
//           |     | last_of_run                                          |
//
// One input request a cycle while the queue has room; results reach out_o via the queue.
// A request that yields two results hands them to out_o one after the other.
// Input register and queue free space (two slots) set when in_i.ready rises.
// Reset returns scan state to normal and empties the queue; no clearing pass.
// Output stalls back up through the queue into the input register.
module backslash_escape_decoder #(
  parameter int unsigned FifoDepth = bsd_pkg::FIFO_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bsd_in_if.sink    in_i,
  bsd_out_if.source out_o
);

  bsd_pkg::push_t   push;
  bsd_pkg::result_t res;
  logic             room;

  bsd_step u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_byte_i  (in_i.in_byte),
    .in_eos_i   (in_i.end_of_string),
    .in_ready_o (in_i.ready),
    .room_i     (room),
    .push_o     (push)
  );

  bsd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_res_o   (res)
  );

  assign out_o.out_byte     = res.out_byte;
  assign out_o.byte_valid   = res.byte_valid;
  assign out_o.string_done  = res.string_done;
  assign out_o.stopped_by_c = res.stopped_by_c;
  assign out_o.last_of_run  = res.last_of_run;

endmodule

// ===== hdl/bsd_checker.sv =====
// Checker: port-level properties of the backslash escape decoder, bound to the top level
module bsd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       byte_valid_i,
  input logic       string_done_i,
  input logic       stopped_by_c_i,
  input logic       last_of_run_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i)
      && $stable(string_done_i))
    else $error("stalled output request changed");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && string_done_i |-> last_of_run_i)
    else $error("closing result not last of run");

  a_stop_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && stopped_by_c_i |-> string_done_i && !byte_valid_i)
    else $error("stop flag outside bare closing result");

  a_bare_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !byte_valid_i |-> string_done_i && (out_byte_i == 8'd0))
    else $error("bare result not a clean close");

endmodule

bind backslash_escape_decoder bsd_checker u_bsd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_byte_i     (out_o.out_byte),
  .byte_valid_i   (out_o.byte_valid),
  .string_done_i  (out_o.string_done),
  .stopped_by_c_i (out_o.stopped_by_c),
  .last_of_run_i  (out_o.last_of_run)
);
